@@ hdl/ekcc_pkg.sv @@
// ----------------------------------------------------------------------------
// ekcc_pkg
// Shared types, keyword tables and color constants for the event keyword
// color classifier.
// ----------------------------------------------------------------------------
package ekcc_pkg;

	localparam int WINDOW_DEPTH_DEF = 12;
	localparam int NUM_FAMILIES     = 6;
	localparam int NUM_KW           = 11;
	localparam int KEY_MAX          = 13;
	localparam int FAM_W            = $clog2(NUM_FAMILIES);

	localparam logic [31:0] GRAY_COLOR = 32'hFFCC_CCCC;

	// colors by family, highest priority first
	localparam logic [31:0] FAMILY_COLOR [NUM_FAMILIES] = '{
		32'hFFFF_D040, 32'hFFFF_4040, 32'hFF40_DDFF,
		32'hFFFF_EE40, 32'hFFFF_40FF, 32'hFF40_FF60
	};

	// keywords right-justified: byte 0 is the last letter
	localparam logic [KEY_MAX*8-1:0] KW_TEXT [NUM_KW] = '{
		(KEY_MAX*8)'("capture"),   (KEY_MAX*8)'("neutralize"),
		(KEY_MAX*8)'("death"),     (KEY_MAX*8)'("die"),
		(KEY_MAX*8)'("trigger"),   (KEY_MAX*8)'("enter"),
		(KEY_MAX*8)'("exit"),      (KEY_MAX*8)'("spawn"),
		(KEY_MAX*8)'("reinforcement"),
		(KEY_MAX*8)'("complete"),  (KEY_MAX*8)'("threshold")
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd7, 4'd10, 4'd5, 4'd3, 4'd7, 4'd5, 4'd4, 4'd5, 4'd13, 4'd8, 4'd9
	};

	localparam logic [FAM_W-1:0] KW_FAMILY [NUM_KW] = '{
		FAM_W'(0), FAM_W'(0), FAM_W'(1), FAM_W'(1), FAM_W'(2), FAM_W'(3),
		FAM_W'(3), FAM_W'(4), FAM_W'(4), FAM_W'(5), FAM_W'(5)
	};

	// one processing step from the input stage to the matcher
	typedef struct packed {
		logic       fire;
		logic       has_char;
		logic       is_last;
		logic [7:0] char_code;
	} step_t;

	// fold A..Z to lower case, everything else unchanged
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	// lowest set family wins, gray if none
	function automatic logic [31:0] pick_color(input logic [NUM_FAMILIES-1:0] found);
		logic [31:0] c;
		c = GRAY_COLOR;
		for (int f = NUM_FAMILIES - 1; f >= 0; f--) begin
			if (found[f]) begin
				c = FAMILY_COLOR[f];
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/event_keyword_color_classifier.sv @@
// ----------------------------------------------------------------------------
// event_keyword_color_classifier
// Classifies an event name, streamed one byte per transaction, into a packed
// 32-bit color by the highest-priority keyword family found in it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per name byte, with
//   is_last set on the final one. An empty name is one transaction with
//   has_char = 0 and is_last = 1. A transaction with both low does nothing.
//   Output channel (out_valid / out_stall): one color per name, carried by
//   the transaction that had is_last set; nothing for other transactions.
// Timing:
//   A transaction is captured in the input stage when accepted and
//   processed from there; the keyword compare and color pick land in
//   the output register, and a name end may wait in the input stage.
//   Throughput is one transaction per cycle while in_stall is low, set
//   by the parallel compare of the byte window against all eleven keywords.
// Reset:
//   Clears the input and output valid flags, the window fill count and the
//   family flags. Window bytes are not reset; unfilled slots are never used.
// Stall:
//   While a color waits in the output register under out_stall, byte
//   transactions keep flowing; only the next name end is held in the input
//   stage, and in_stall rises once that stage is occupied by it.
// ----------------------------------------------------------------------------
module event_keyword_color_classifier #(
	parameter int WINDOW_DEPTH = ekcc_pkg::WINDOW_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        has_char,
	input  logic        is_last,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] color
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       has_s1;
	logic       last_s1;

	logic                              adv_s1;
	logic                              out_free;
	logic [ekcc_pkg::NUM_FAMILIES-1:0] found;
	ekcc_pkg::step_t                   step;

	// a name end can only move on when the output register has room
	assign in_stall = valid_s1 && last_s1 && !out_free;
	assign adv_s1   = valid_s1 && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			has_s1  <= has_char;
			last_s1 <= is_last;
		end
	end

	assign step = '{fire: adv_s1, has_char: has_s1, is_last: last_s1, char_code: char_s1};

	ekcc_matcher #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_matcher (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.found  (found)
	);

	ekcc_color_out u_color_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv_s1 && last_s1),
		.found     (found),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.color     (color)
	);

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid)
		else $error("input stalled without a pending name end");

	a_end_gives_color: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid)
		else $error("name end processed but no color presented");
`endif

endmodule

@@ hdl/ekcc_matcher.sv @@
// ----------------------------------------------------------------------------
// ekcc_matcher
// Byte window, fill count and family flags; checks the incoming byte against
// every keyword as its final letter, combinationally.
// ----------------------------------------------------------------------------
module ekcc_matcher #(
	parameter int WINDOW_DEPTH = ekcc_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ekcc_pkg::step_t                     step,
	output logic [ekcc_pkg::NUM_FAMILIES-1:0]   found
);

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

	logic [7:0]                          recent_q [WINDOW_DEPTH];
	logic [FILL_W-1:0]                   fill_q;
	logic [ekcc_pkg::NUM_FAMILIES-1:0]   found_q;
	logic [ekcc_pkg::NUM_FAMILIES-1:0]   hit;
	logic [7:0]                          cur;
	logic                                kw_ok;

	always_comb begin
		cur = ekcc_pkg::fold_case(step.char_code);
		hit = '0;
		kw_ok = 1'b0;
		for (int k = 0; k < ekcc_pkg::NUM_KW; k++) begin
			kw_ok = (cur == ekcc_pkg::KW_TEXT[k][7:0]) &&
				((32'(fill_q) + 32'd1) >= 32'(ekcc_pkg::KW_LEN[k]));
			// window entry j holds the byte j+1 places before the current one
			for (int j = 0; j < ekcc_pkg::KEY_MAX - 1; j++) begin
				if ((j + 1) < int'(ekcc_pkg::KW_LEN[k]) &&
					recent_q[j] != ekcc_pkg::KW_TEXT[k][8*(j+1) +: 8]) begin
					kw_ok = 1'b0;
				end
			end
			if (kw_ok) begin
				hit[ekcc_pkg::KW_FAMILY[k]] = 1'b1;
			end
		end
		found = found_q | (step.has_char ? hit : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			found_q <= '0;
		end else if (step.fire) begin
			if (step.is_last) begin
				fill_q  <= '0;
				found_q <= '0;
			end else if (step.has_char) begin
				found_q <= found;
				if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// window shift line; its reads are gated by fill_q so it needs no reset
	always_ff @(posedge clk) begin
		if (step.fire && step.has_char) begin
			recent_q[0] <= cur;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= WINDOW_DEPTH)
		else $error("window fill count beyond depth");

	a_name_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && step.is_last |=> fill_q == '0 && found_q == '0)
		else $error("state not cleared after name end");
`endif

endmodule

@@ hdl/ekcc_color_out.sv @@
// ----------------------------------------------------------------------------
// ekcc_color_out
// Priority color pick and the output register of the result channel.
// ----------------------------------------------------------------------------
module ekcc_color_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [ekcc_pkg::NUM_FAMILIES-1:0]   found,
	output logic                                out_free,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [31:0]                         color
);

	logic        out_valid_q;
	logic [31:0] color_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign color     = color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= ekcc_pkg::pick_color(found);
		end
	end

`ifndef SYNTHESIS
	a_gray_default: assert property (@(posedge clk) disable iff (!arst_n)
		load && found == '0 |=> color_q == ekcc_pkg::GRAY_COLOR)
		else $error("no family found but color is not gray");
`endif

endmodule
